// ===== sv/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned OccWidth    = 5;

  typedef logic [OpWidth-1:0] op_t;

  localparam op_t OpAddBack     = 3'd0;
  localparam op_t OpAddFront    = 3'd1;
  localparam op_t OpRemoveFront = 3'd2;
  localparam op_t OpRemoveBack  = 3'd3;
  localparam op_t OpSearch      = 3'd4;

  typedef enum logic [StatusWidth-1:0] {
    StDone,
    StEmptyRemove,
    StFull,
    StFound,
    StNotFound,
    StEmptySearch
  } status_e;

  typedef struct packed {
    logic load_item;
    logic exec_op;
    logic search_start;
    logic search_step;
    logic push_out;
  } deq_cmd_t;

  typedef struct packed {
    logic is_search;
    logic empty;
    logic hit;
    logic last;
  } deq_sts_t;

endpackage

// ===== sv/deq_if.sv =====
interface deq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic        [deq_pkg::OpWidth-1:0]     operation;
  logic signed [deq_pkg::ValueWidth-1:0]  value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface deq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [deq_pkg::StatusWidth-1:0]    status;
  logic [deq_pkg::OccWidth-1:0]       occupancy;

  modport source (output valid, status, occupancy, input ready);
  modport sink (input valid, status, occupancy, output ready);
endinterface

// ===== sv/deq_ram.sv =====
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/deq_dp.sv =====
module deq_dp #(
  parameter int unsigned CAPACITY   = deq_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = deq_pkg::ValueBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  deq_pkg::deq_cmd_t                     cmd_i,
  output deq_pkg::deq_sts_t                     sts_o,
  input  logic        [deq_pkg::OpWidth-1:0]    operation_i,
  input  logic signed [deq_pkg::ValueWidth-1:0] value_i,
  output logic        [deq_pkg::StatusWidth-1:0] status_o,
  output logic        [deq_pkg::OccWidth-1:0]   occupancy_o
);

  import deq_pkg::*;

  localparam int unsigned PosW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = PosW + 1;

  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);
  localparam logic [PosW-1:0] CapLast = PosW'(CAPACITY - 1);
  localparam logic [SumW-1:0] CapSum  = SumW'(CAPACITY);

  logic [OpWidth-1:0]    op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [PosW-1:0]       front_q, front_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [PosW-1:0]       ptr_q, ptr_d;
  logic [PosW-1:0]       cmp_q, cmp_d;
  status_e               res_q, res_d;
  logic [StatusWidth-1:0] out_status_q;
  logic [OccWidth-1:0]   out_occ_q;

  logic                  full, empty, hit, last;
  logic [SumW-1:0]       back_sum;
  logic [PosW-1:0]       back_pos, front_prev, front_next, ptr_next;
  logic                  ram_we;
  logic [PosW-1:0]       ram_addr;
  logic [VALUE_BITS-1:0] ram_rdata;

  assign full       = count_q == CapCnt;
  assign empty      = count_q == '0;
  assign back_sum   = SumW'(front_q) + SumW'(count_q);
  assign back_pos   = (back_sum >= CapSum) ? PosW'(back_sum - CapSum) : PosW'(back_sum);
  assign front_prev = (front_q == '0) ? CapLast : front_q - PosW'(1);
  assign front_next = (front_q == CapLast) ? '0 : front_q + PosW'(1);
  assign ptr_next   = (ptr_q == CapLast) ? '0 : ptr_q + PosW'(1);
  assign hit        = ram_rdata == val_q;
  assign last       = CntW'(cmp_q) == (count_q - CntW'(1));

  assign sts_o.is_search = op_q == OpSearch;
  assign sts_o.empty     = empty;
  assign sts_o.hit       = hit;
  assign sts_o.last      = last;

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    cmp_d    = cmp_q;
    res_d    = res_q;
    ram_we   = 1'b0;
    ram_addr = ptr_q;
    if (cmd_i.exec_op) begin
      res_d = StDone;
      unique case (op_q)
        OpAddBack: begin
          if (full) begin
            res_d = StFull;
          end else begin
            ram_we   = 1'b1;
            ram_addr = back_pos;
            count_d  = count_q + CntW'(1);
          end
        end
        OpAddFront: begin
          if (full) begin
            res_d = StFull;
          end else begin
            ram_we   = 1'b1;
            ram_addr = front_prev;
            front_d  = front_prev;
            count_d  = count_q + CntW'(1);
          end
        end
        OpRemoveFront: begin
          if (empty) begin
            res_d = StEmptyRemove;
          end else begin
            front_d = front_next;
            count_d = count_q - CntW'(1);
          end
        end
        OpRemoveBack: begin
          if (empty) begin
            res_d = StEmptyRemove;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        OpSearch: begin
          if (empty) begin
            res_d = StEmptySearch;
          end
        end
        default: begin
          res_d = StDone;
        end
      endcase
    end else if (cmd_i.search_start) begin
      ram_addr = front_q;
      ptr_d    = front_next;
      cmp_d    = '0;
    end else if (cmd_i.search_step) begin
      ram_addr = ptr_q;
      ptr_d    = ptr_next;
      cmp_d    = cmp_q + PosW'(1);
      if (hit) begin
        res_d = StFound;
      end else if (last) begin
        res_d = StNotFound;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= operation_i;
      val_q <= VALUE_BITS'(value_i);
    end
    ptr_q <= ptr_d;
    cmp_q <= cmp_d;
    res_q <= res_d;
    if (cmd_i.push_out) begin
      out_status_q <= res_q;
      out_occ_q    <= OccWidth'(count_q);
    end
  end

  deq_ram #(
    .Width (VALUE_BITS),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

endmodule

// ===== sv/deq_ctrl.sv =====
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  deq_pkg::deq_sts_t sts_i,
  output deq_pkg::deq_cmd_t cmd_o
);

  import deq_pkg::*;

  localparam logic [1:0] StateIdle   = 2'd0;
  localparam logic [1:0] StateExec   = 2'd1;
  localparam logic [1:0] StateSearch = 2'd2;
  localparam logic [1:0] StateDone   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign req_ready_o = state_q == StateIdle;
  assign rsp_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StateIdle: begin
        if (req_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StateExec;
        end
      end
      StateExec: begin
        if (sts_i.is_search && !sts_i.empty) begin
          cmd_o.search_start = 1'b1;
          state_d            = StateSearch;
        end else begin
          cmd_o.exec_op = 1'b1;
          state_d       = StateDone;
        end
      end
      StateSearch: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = StateDone;
        end
      end
      StateDone: begin
        if (out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/double_ended_queue_with_search_unit.sv =====
// Bounded double-ended queue of signed values with a linear search.
// Requests arrive on req_i (operation, value) and each one produces exactly
// one response on rsp_o (status, occupancy after the operation).
// Operations are add at back, add at front, remove front, remove back and
// search. Adds on a full queue and removes on an empty one change nothing and
// are flagged in the status.
// A request is taken in the Idle state and executed in the cycle after it is
// taken. Adds, removes and a search of an empty queue then pass to the Done
// state, which registers the response. A search reads the ring store one entry
// per cycle through the single RAM port until a match or the last entry held,
// so it compares at most CAPACITY entries. One request is in flight at a time.
// A finished response waits in an output register; the next request is taken
// while it waits, and a further response holds until rsp_o is ready.
// Reset empties the queue and clears the response valid; the store contents
// are not cleared and need no clearing pass.
module double_ended_queue_with_search_unit #(
  parameter int unsigned CAPACITY   = deq_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = deq_pkg::ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  deq_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (req_i.operation),
    .value_i     (req_i.value),
    .status_o    (rsp_o.status),
    .occupancy_o (rsp_o.occupancy)
  );

endmodule
